// ===== rtl/first_fit_segment_allocator_defines.svh =====
// assertion macros for the first-fit segment allocator
`ifndef FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_SEGMENT_ALLOCATOR_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define FFSA_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define FFSA_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ffsa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffsa_pkg
// types and codes shared by the segment allocator cells and top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ffsa_pkg;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_INIT  = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CFG_TOTAL        = 2'd0,
        CFG_KERNEL_START = 2'd1,
        CFG_KERNEL_END   = 2'd2,
        CFG_HEADER       = 2'd3
    } cfg_index_t;

    // what every cell does in the update cycle
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INIT,
        OP_ALLOC,
        OP_FREE
    } cell_op_t;

    typedef struct packed {
        logic [31:0] start;
        logic [31:0] size;
        logic        used;
    } seg_t;

    // broadcast command from the controller to all cells
    typedef struct packed {
        cell_op_t    op;
        logic [31:0] size;
        logic [31:0] init_start;
        logic [31:0] init_size;
        logic        split;
        logic        merge;
    } cell_cmd_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PICK,
        S_UPDATE,
        S_OUT
    } state_t;

    localparam logic [31:0] RESET_TOTAL        = 32'd134217728;
    localparam logic [31:0] RESET_KERNEL_START = 32'd1048576;
    localparam logic [31:0] RESET_KERNEL_END   = 32'd2097152;
    localparam logic [7:0]  RESET_HEADER       = 8'd16;

endpackage

`default_nettype wire

// ===== rtl/ffsa_cell.sv =====
// ----------------------------------------------------------------------------
// ffsa_cell
// one table entry: holds a segment, flags fit and address match, and takes
// its new value from itself, a neighbor or the command on a table update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffsa_cell (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               is_first,
    input  wire ffsa_pkg::cell_cmd_t cmd,
    input  wire logic               valid_in,     // index < count
    input  wire logic               sel_here,     // this cell is the chosen one
    input  wire logic               sel_left,     // left neighbor is chosen
    input  wire logic               after_sel,    // index above chosen + 1
    input  wire ffsa_pkg::seg_t     left_seg,
    input  wire ffsa_pkg::seg_t     right_seg,
    input  wire logic [31:0]        req_size,
    input  wire logic [31:0]        req_addr,
    output ffsa_pkg::seg_t          seg,
    output logic                    fit,
    output logic                    match
);
    import ffsa_pkg::*;

    seg_t seg_reg, seg_next;

    assign seg   = seg_reg;
    assign fit   = valid_in && !seg_reg.used && (seg_reg.size >= req_size);
    assign match = valid_in && (seg_reg.start == req_addr);

    always_comb begin
        seg_next = seg_reg;
        case (cmd.op)
            OP_INIT: begin
                if (is_first) begin
                    seg_next.start = cmd.init_start;
                    seg_next.size  = cmd.init_size;
                end
                seg_next.used = 1'b0;
            end
            OP_ALLOC: begin
                if (sel_here) begin
                    seg_next.used = 1'b1;
                    seg_next.size = cmd.size;
                end else if (sel_left && cmd.split) begin
                    seg_next.start = left_seg.start + cmd.size;
                    seg_next.size  = left_seg.size - cmd.size;
                    seg_next.used  = 1'b0;
                end else if (after_sel && cmd.split) begin
                    seg_next = left_seg;
                end
            end
            OP_FREE: begin
                if (sel_here) begin
                    seg_next.used = 1'b0;
                    if (cmd.merge) seg_next.size = seg_reg.size + right_seg.size;
                end else if ((sel_left || after_sel) && cmd.merge) begin
                    seg_next = right_seg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg.used <= 1'b0;
            if (is_first) begin
                seg_reg.start <= RESET_KERNEL_END;
                seg_reg.size  <= RESET_TOTAL - RESET_KERNEL_END;
            end
        end else begin
            seg_reg <= seg_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ffsa_pick.sv =====
// ----------------------------------------------------------------------------
// ffsa_pick
// priority pick of the lowest set flag, as an encoded index and an any flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ffsa_pick #(
    parameter int N  = 64,
    parameter int IW = 6
) (
    input  wire logic [N-1:0]  flags,
    output logic               any,
    output logic [IW-1:0]      idx
);
    logic [N-1:0] lower;

    // lower[i]: some flag below i is set
    always_comb begin
        lower[0] = 1'b0;
        for (int i = 1; i < N; i++) lower[i] = lower[i-1] | flags[i-1];
    end

    always_comb begin
        idx = '0;
        for (int i = 0; i < N; i++) begin
            if (flags[i] && !lower[i]) idx = idx | IW'(i);
        end
        any = |flags;
    end

endmodule

`default_nettype wire

// ===== rtl/first_fit_segment_allocator.sv =====
// each request passes the states pick, table update and output in that order
// one request is handled at a time; the table shift runs in
// the cell row in the update state after the registered priority pick
// the output register is freed when taken, input is held off until then
// reset: synchronous active low; table holds one free segment from the reset
// kernel_end to the reset total_bytes; state, count, used, config regs reset
`timescale 1ns / 1ps
`default_nettype none

// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// address-ordered first-fit segment table built as a row of cells
// ----------------------------------------------------------------------------
module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS = 64
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [63:0] s_tdata,   // req_size[31:0], req_addr[63:32]
    input  wire logic [1:0]  s_tuser,   // req_type[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [95:0]      m_tdata,   // result_addr, used_bytes, free_bytes
    output logic [1:0]       m_tuser,   // status[1:0]
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata
);
    import ffsa_pkg::*;

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);

    // configuration registers
    logic [31:0] total_reg, kstart_reg, kend_reg;
    logic [7:0]  header_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg  <= RESET_TOTAL;
            kstart_reg <= RESET_KERNEL_START;
            kend_reg   <= RESET_KERNEL_END;
            header_reg <= RESET_HEADER;
        end else if (cfg_we) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_TOTAL:        total_reg  <= cfg_wdata;
                CFG_KERNEL_START: kstart_reg <= cfg_wdata;
                CFG_KERNEL_END:   kend_reg   <= cfg_wdata;
                CFG_HEADER:       header_reg <= cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    // request capture
    state_t      state_reg, state_next;
    req_type_t   type_reg;
    logic [31:0] size_reg, addr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0] used_reg, used_next;

    // pick results registered for the update cycle
    logic          found_reg;
    logic [IW-1:0] sel_reg;

    // output register
    logic [1:0]  st_reg, st_next;
    logic [31:0] raddr_reg, raddr_next;

    logic [MAX_SEGMENTS-1:0] fit_v, match_v, valid_v;
    seg_t                    segs [MAX_SEGMENTS];
    logic                    any_hit;
    logic [IW-1:0]           hit_idx;
    cell_cmd_t               cmd;

    always_comb
        for (int i = 0; i < MAX_SEGMENTS; i++) valid_v[i] = CW'(i) < count_reg;

    ffsa_pick #(.N(MAX_SEGMENTS), .IW(IW)) u_pick (
        .flags (type_reg == REQ_FREE ? match_v : fit_v),
        .any   (any_hit),
        .idx   (hit_idx)
    );

    // chosen segment and its right neighbor, read in the update cycle
    seg_t     sel_seg, nxt_seg;
    logic     nxt_valid;
    logic [IW:0] nxt_i;
    assign nxt_i     = {1'b0, sel_reg} + 1'b1;
    assign sel_seg   = segs[sel_reg];
    assign nxt_valid = (CW'(nxt_i) < count_reg);
    assign nxt_seg   = segs[nxt_valid ? nxt_i[IW-1:0] : sel_reg];

    logic split, merge, full;
    // 33-bit split compare
    assign split = {1'b0, sel_seg.size} > ({1'b0, size_reg} + 33'(header_reg));
    assign full  = count_reg >= CW'(MAX_SEGMENTS);
    assign merge = nxt_valid && !nxt_seg.used;

    // command to the cell row
    always_comb begin
        cmd            = '0;
        cmd.op         = OP_HOLD;
        cmd.size       = size_reg;
        cmd.init_start = kend_reg;
        cmd.init_size  = total_reg - kend_reg;
        cmd.split      = split;
        cmd.merge      = merge;
        if (state_reg == S_UPDATE) begin
            unique case (type_reg)
                REQ_INIT:  cmd.op = OP_INIT;
                REQ_ALLOC: if (found_reg && size_reg != '0 && !(split && full))
                               cmd.op = OP_ALLOC;
                REQ_FREE:  if (found_reg) cmd.op = OP_FREE;
                default: ;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
            seg_t lseg, rseg;
            if (g == 0) begin : g_l0
                assign lseg = '0;
            end else begin : g_ln
                assign lseg = segs[g-1];
            end
            if (g == MAX_SEGMENTS - 1) begin : g_rn
                assign rseg = '0;
            end else begin : g_rr
                assign rseg = segs[g+1];
            end
            ffsa_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .is_first  (g == 0),
                .cmd       (cmd),
                .valid_in  (valid_v[g]),
                .sel_here  (sel_reg == IW'(g)),
                .sel_left  (g != 0 && sel_reg == IW'(g - 1)),
                .after_sel ({1'b0, sel_reg} + 1'b1 < (IW + 1)'(g)),
                .left_seg  (lseg),
                .right_seg (rseg),
                .req_size  (size_reg),
                .req_addr  (addr_reg),
                .seg       (segs[g]),
                .fit       (fit_v[g]),
                .match     (match_v[g])
            );
        end
    endgenerate

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (s_tvalid) state_next = S_PICK;
            S_PICK:   state_next = S_UPDATE;
            S_UPDATE: state_next = S_OUT;
            S_OUT:    if (m_tready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // outputs and bookkeeping of the update cycle
    always_comb begin
        count_next = count_reg;
        used_next  = used_reg;
        st_next    = st_reg;
        raddr_next = raddr_reg;
        if (state_reg == S_UPDATE) begin
            st_next    = ST_OK;
            raddr_next = '0;
            unique case (type_reg)
                REQ_INIT: begin
                    count_next = CW'(1);
                    used_next  = kend_reg - kstart_reg;
                end
                REQ_ALLOC: begin
                    if (size_reg == '0 || !found_reg) st_next = ST_NOFIT;
                    else if (split && full) st_next = ST_FULL;
                    else begin
                        if (split) count_next = count_reg + 1'b1;
                        used_next  = used_reg + size_reg;
                        raddr_next = sel_seg.start;
                    end
                end
                REQ_FREE: begin
                    if (!found_reg) st_next = ST_NOTFOUND;
                    else begin
                        used_next = used_reg - sel_seg.size;
                        if (merge) count_next = count_reg - 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            count_reg <= CW'(1);
            used_reg  <= RESET_KERNEL_END - RESET_KERNEL_START;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            used_reg  <= used_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            type_reg <= req_type_t'(s_tuser);
            size_reg <= s_tdata[31:0];
            addr_reg <= s_tdata[63:32];
        end
        found_reg <= any_hit;
        sel_reg   <= hit_idx;
        st_reg    <= st_next;
        raddr_reg <= raddr_next;
    end

    // the captured request drives the pick during S_PICK, its result is
    // registered at the end of that cycle and used in S_UPDATE
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tuser  = st_reg;
    assign m_tdata  = {total_reg - used_reg, used_reg, raddr_reg};

    `include "first_fit_segment_allocator_defines.svh"

    `FFSA_ASSERT_IMP(a_count_range, aclk, aresetn, 1'b1, count_reg >= CW'(1) && count_reg <= CW'(MAX_SEGMENTS), "segment count out of range")
    `FFSA_ASSERT_NEXT(a_out_follows, aclk, aresetn, state_reg == S_UPDATE, m_tvalid, "result not presented after update")
    `FFSA_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, m_tvalid, !s_tready, "input accepted while result pending")

endmodule

`default_nettype wire

// ===== verif/first_fit_segment_allocator_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_tb
// drives allocate, free, init and none requests into the segment allocator with
// random gaps and stalls, predicts each response from a local copy of the
// segment table and compares every response field against the prediction
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_tb;
    import ffsa_pkg::*;

    localparam int SEGS     = 64;
    localparam int WD_LIMIT = 2000;

    typedef struct {
        req_type_t   kind;
        logic [31:0] size;
        logic [31:0] addr;
    } req_t;

    typedef struct {
        status_t     status;
        logic [31:0] addr;
        logic [31:0] used;
        logic [31:0] free;
    } rsp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_wdata = '0;

    // predictor copy of configuration and segment table
    logic [31:0] mem_total, kstart, kend;
    logic [7:0]  hdr;
    logic [31:0] tbl_start [SEGS];
    logic [31:0] tbl_size  [SEGS];
    logic        tbl_used  [SEGS];
    int          tbl_count;
    logic [31:0] used_ctr;

    req_t pending_reqs[$];
    rsp_t expected_rsps[$];
    int   errors = 0;
    int   idle_cycles = 0;
    int   s_wait = 0, m_wait = 0;
    bit   stim_done = 0;
    // transactions seen at the last rising edge
    bit   s_taken = 0, m_taken = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    first_fit_segment_allocator #(.MAX_SEGMENTS(SEGS)) i_dut (.*);

    function automatic void rebuild();
        tbl_start[0] = kend;
        tbl_size[0]  = mem_total - kend;
        tbl_used[0]  = 1'b0;
        tbl_count    = 1;
        used_ctr     = kend - kstart;
    endfunction

    // compute the response for one request and update the table
    function automatic rsp_t allocate_step(req_t r);
        rsp_t o;
        bit   done;
        o.status = ST_OK;
        o.addr = '0;
        done = 0;
        if (r.kind == REQ_ALLOC) begin
            o.status = ST_NOFIT;
            if (r.size != 0) begin
                for (int i = 0; i < tbl_count && !done; i++) begin
                    if (!tbl_used[i] && tbl_size[i] >= r.size) begin
                        done = 1;
                        if ({1'b0, tbl_size[i]} > {1'b0, r.size} + 33'(hdr)) begin
                            if (tbl_count >= SEGS) begin
                                o.status = ST_FULL;
                            end else begin
                                for (int k = tbl_count; k > i + 1; k--) begin
                                    tbl_start[k] = tbl_start[k-1];
                                    tbl_size[k]  = tbl_size[k-1];
                                    tbl_used[k]  = tbl_used[k-1];
                                end
                                tbl_start[i+1] = tbl_start[i] + r.size;
                                tbl_size[i+1]  = tbl_size[i] - r.size;
                                tbl_used[i+1]  = 1'b0;
                                tbl_count++;
                            end
                        end
                        if (o.status != ST_FULL) begin
                            tbl_used[i] = 1'b1;
                            tbl_size[i] = r.size;
                            used_ctr += r.size;
                            o.addr = tbl_start[i];
                            o.status = ST_OK;
                        end
                    end
                end
            end
        end else if (r.kind == REQ_FREE) begin
            o.status = ST_NOTFOUND;
            for (int i = 0; i < tbl_count && !done; i++) begin
                if (tbl_start[i] == r.addr) begin
                    done = 1;
                    o.status = ST_OK;
                    tbl_used[i] = 1'b0;
                    used_ctr -= tbl_size[i];
                    if (i + 1 < tbl_count && !tbl_used[i+1]) begin
                        tbl_size[i] += tbl_size[i+1];
                        for (int k = i + 1; k + 1 < tbl_count; k++) begin
                            tbl_start[k] = tbl_start[k+1];
                            tbl_size[k]  = tbl_size[k+1];
                            tbl_used[k]  = tbl_used[k+1];
                        end
                        tbl_count--;
                    end
                end
            end
        end else if (r.kind == REQ_INIT) begin
            rebuild();
        end
        o.used = used_ctr;
        o.free = mem_total - used_ctr;
        return o;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] exp);
        $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    // handshake capture at the rising edge for the falling-edge drivers
    always @(posedge aclk) begin
        s_taken <= s_tvalid && s_tready;
        m_taken <= m_tvalid && m_tready;
    end

    // driver: presents queued requests with random gaps
    always @(negedge aclk) begin
        if (aresetn) begin
            if (s_taken) begin
                // transaction taken at the preceding rising edge
                expected_rsps.push_back(allocate_step(pending_reqs.pop_front()));
                s_wait = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
            end
            if (pending_reqs.size() > 0 && s_wait == 0) begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_reqs[0].kind;
                s_tdata  <= {pending_reqs[0].addr, pending_reqs[0].size};
            end else begin
                s_tvalid <= 1'b0;
                if (s_wait > 0) s_wait--;
            end
        end
    end

    // receiver stall pattern, redrawn after every response
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_taken)
                m_wait = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 13);
            if (m_wait > 0) begin
                m_tready <= 1'b0;
                m_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // monitor: compare each response against the oldest prediction
    always @(posedge aclk) begin
        rsp_t e;
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                if (expected_rsps.size() == 0) begin
                    report("unexpected response", m_tdata[31:0], '0);
                end else begin
                    e = expected_rsps.pop_front();
                    if (m_tuser != e.status) report("status", 32'(m_tuser), 32'(e.status));
                    if (m_tdata[31:0] != e.addr) report("result_addr", m_tdata[31:0], e.addr);
                    if (m_tdata[63:32] != e.used) report("used_bytes", m_tdata[63:32], e.used);
                    if (m_tdata[95:64] != e.free) report("free_bytes", m_tdata[95:64], e.free);
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (idle_cycles >= WD_LIMIT) begin
            $display("watchdog expired");
            $display("** first_fit_segment_allocator: FAILED **");
            $finish;
        end
    end

    task automatic push(req_type_t k, logic [31:0] sz, logic [31:0] ad);
        req_t r;
        r.kind = k;
        r.size = sz;
        r.addr = ad;
        pending_reqs.push_back(r);
    endtask

    // wait until every request is answered and the block has settled
    task automatic drain();
        while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_cfg(cfg_index_t idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_TOTAL:        mem_total = val;
            CFG_KERNEL_START: kstart = val;
            CFG_KERNEL_END:   kend = val;
            default:          hdr = val[7:0];
        endcase
    endtask

    // random phase: mostly well-formed alloc/free traffic at a chosen scale
    task automatic random_phase(int n, int max_size);
        logic [31:0] sz, ad;
        int pick;
        for (int j = 0; j < n; j++) begin
            pick = $urandom_range(0, 99);
            sz = $urandom_range(1, max_size);
            if (pick < 2) sz = $urandom;
            if (pick < 50) begin
                push(REQ_ALLOC, sz, $urandom);
            end else if (pick < 92) begin
                // free a grid address or, half the time, a start from the predictor's table
                ad = kend + 32'($urandom_range(0, 8) * max_size);
                if (tbl_count > 0 && $urandom_range(0, 1)) ad = tbl_start[$urandom_range(0, tbl_count - 1)];
                push(REQ_FREE, $urandom, ad);
            end else if (pick < 96) begin
                push(REQ_FREE, $urandom, $urandom);
            end else if (pick < 98) begin
                push(REQ_NONE, $urandom, $urandom);
            end else begin
                push(REQ_INIT, $urandom, $urandom);
            end
            if (j % 40 == 39) while (pending_reqs.size() > 0) @(posedge aclk);
        end
        drain();
    endtask

    initial begin
        mem_total = RESET_TOTAL;
        kstart    = RESET_KERNEL_START;
        kend      = RESET_KERNEL_END;
        hdr       = RESET_HEADER;
        rebuild();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed part on reset configuration
        push(REQ_ALLOC, 32'd0, 32'd0);             // zero size refused
        push(REQ_ALLOC, 32'hFFFF_FFFF, 32'd0);     // no fit
        push(REQ_ALLOC, 32'd100, 32'hFFFF_FFFF);
        push(REQ_ALLOC, 32'd200, 32'd0);
        push(REQ_FREE, 32'd0, 32'h1234_5678);      // address not found
        push(REQ_FREE, 32'hFFFF_FFFF, RESET_KERNEL_END);
        push(REQ_FREE, 32'd0, RESET_KERNEL_END);   // free of a free segment
        push(REQ_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push(REQ_INIT, 32'd0, 32'd0);
        push(REQ_ALLOC, RESET_TOTAL - RESET_KERNEL_END - 32'd16, 32'd0); // no split, tail dropped
        push(REQ_FREE, 32'd0, RESET_KERNEL_END);
        push(REQ_INIT, 32'd0, 32'd0);
        drain();

        // table full: small total, header zero, many one-byte splits
        write_cfg(CFG_TOTAL, 32'd1000);
        write_cfg(CFG_KERNEL_START, 32'd0);
        write_cfg(CFG_KERNEL_END, 32'd0);
        write_cfg(CFG_HEADER, 8'd0);
        push(REQ_INIT, 32'd0, 32'd0);
        for (int j = 0; j < SEGS + 2; j++) push(REQ_ALLOC, 32'd1, 32'd0);
        drain();

        random_phase(350, 40);

        // extremes: full 32-bit range, maximum header, wrapping counter
        write_cfg(CFG_TOTAL, 32'hFFFF_FFFF);
        write_cfg(CFG_KERNEL_START, 32'hFFFF_FFFF);
        write_cfg(CFG_KERNEL_END, 32'd0);
        write_cfg(CFG_HEADER, 8'hFF);
        push(REQ_INIT, 32'd0, 32'd0);
        push(REQ_ALLOC, 32'hFFFF_FF00, 32'd0);     // split compare at the top of range
        push(REQ_ALLOC, 32'hFFFF_FFFF, 32'd0);
        drain();
        random_phase(350, 300);

        write_cfg(CFG_TOTAL, 32'h0000_4000);
        write_cfg(CFG_KERNEL_START, 32'h0000_0100);
        write_cfg(CFG_KERNEL_END, 32'h0000_0200);
        write_cfg(CFG_HEADER, 8'd8);
        push(REQ_INIT, 32'd0, 32'd0);
        random_phase(450, 200);

        write_cfg(CFG_TOTAL, RESET_TOTAL);
        write_cfg(CFG_KERNEL_START, RESET_KERNEL_START);
        write_cfg(CFG_KERNEL_END, RESET_KERNEL_END);
        write_cfg(CFG_HEADER, RESET_HEADER);
        push(REQ_INIT, 32'd0, 32'd0);
        random_phase(350, 1 << 20);

        if (errors == 0) begin
            $display("** first_fit_segment_allocator: PASSED **");
        end else begin
            $display("** first_fit_segment_allocator: FAILED **");
        end
        $finish;
    end

endmodule
